// ===== hw/rtl/swq_pkg.sv =====
// Package for the sorted wake-up queue.
// Holds the command codes, result status codes and the entry and cell control types.
// No dependencies.
`default_nettype none

package swq_pkg;

    // Width of a wake tick and of a task id.
    localparam int TICK_W = 32;
    localparam int ID_W   = 8;

    // Command codes.
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_POP = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_ID    = 3'd1,
        ST_FULL      = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_NOT_DUE   = 3'd4,
        ST_DUPLICATE = 3'd5
    } status_t;

    // One queue entry as held by a cell.
    typedef struct packed {
        logic              valid;
        logic [TICK_W-1:0] tick;
        logic [ID_W-1:0]   id;
    } entry_t;

    // Operation broadcast to every cell in a cycle.
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/swq_cell.sv =====
// One cell of the sorted queue chain: holds a single entry.
// On insert it keeps, takes the new entry or takes its left neighbor; on pop it takes
// its right neighbor. Depends on swq_pkg.
`default_nettype none

module swq_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire swq_pkg::cell_op_t           op,
    input  wire logic [swq_pkg::TICK_W-1:0]  new_tick,
    input  wire logic [swq_pkg::ID_W-1:0]    new_id,
    input  wire swq_pkg::entry_t             prev_entry,
    input  wire logic                        prev_le,
    input  wire swq_pkg::entry_t             next_entry,
    output swq_pkg::entry_t                  entry,
    output logic                             le
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [swq_pkg::TICK_W-1:0] tick_reg;
    logic [swq_pkg::TICK_W-1:0] tick_next;
    logic [swq_pkg::ID_W-1:0]   id_reg;
    logic [swq_pkg::ID_W-1:0]   id_next;

    // This entry stays in place on insert when it wakes no later than the new one.
    assign le = valid_reg && (tick_reg <= new_tick);

    assign entry.valid = valid_reg;
    assign entry.tick  = tick_reg;
    assign entry.id    = id_reg;

    // Choose what the cell holds after this cycle.
    always_comb
    begin
        valid_next = valid_reg;
        tick_next  = tick_reg;
        id_next    = id_reg;
        if (op.pop)
        begin
            valid_next = next_entry.valid;
            tick_next  = next_entry.tick;
            id_next    = next_entry.id;
        end
        else if (op.ins && !le)
        begin
            if (prev_le)
            begin
                valid_next = 1'b1;
                tick_next  = new_tick;
                id_next    = new_id;
            end
            else
            begin
                valid_next = prev_entry.valid;
                tick_next  = prev_entry.tick;
                id_next    = prev_entry.id;
            end
        end
    end

    // The valid flag is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Tick and id are payload and carry no reset.
    always_ff @(posedge clk)
    begin
        tick_reg <= tick_next;
        id_reg   <= id_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_wakeup_queue_unit.sv =====
// Top level of the sorted wake-up queue: command register, checks, cell chain and
// result register. Depends on swq_pkg and swq_cell.
`default_nettype none

// Channel  Handshake            Payload
// -------  -------------------  ------------------------------
// input    in_valid / in_stall  cmd, task_id, tick_value
// output   out_valid/out_stall  status, woken_task
//
// Each command is first held in the command register on its input transfer; on execution
// the checks run against the head cell and every cell of the chain is updated at once,
// which also loads the result register.
// Reset clears the cell valid flags, the entry count and the per-id queued marks.
// A waiting result blocks execution of the next command but not its input transfer.

module sorted_wakeup_queue_unit #(
    parameter int QUEUE_SLOTS = 64,
    parameter int TASK_LIMIT  = 63
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        cmd,
    input  wire logic [swq_pkg::ID_W-1:0]    task_id,
    input  wire logic [swq_pkg::TICK_W-1:0]  tick_value,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [2:0]                       status,
    output logic [swq_pkg::ID_W-1:0]         woken_task
);

    // The queue reports full one entry short of the slot count.
    localparam int CELLS  = QUEUE_SLOTS - 1;
    localparam int CNT_W  = $clog2(QUEUE_SLOTS);
    localparam int MARK_N = TASK_LIMIT + 1;
    localparam int MARK_W = (MARK_N > 1) ? $clog2(MARK_N) : 1;
    localparam logic [swq_pkg::ID_W-1:0] LIMIT_ID = swq_pkg::ID_W'(TASK_LIMIT);
    localparam logic [CNT_W-1:0]         FULL_CNT = CNT_W'(QUEUE_SLOTS - 1);

    // Command register.
    logic                       stage_valid_reg;
    logic                       stage_valid_next;
    logic                       stage_cmd_reg;
    logic [swq_pkg::ID_W-1:0]   stage_id_reg;
    logic [swq_pkg::TICK_W-1:0] stage_tick_reg;

    // Queue bookkeeping.
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [MARK_N-1:0] mark_reg;
    logic [MARK_N-1:0] mark_next;

    // Result register.
    logic                     out_valid_reg;
    logic                     out_valid_next;
    swq_pkg::status_t         status_reg;
    swq_pkg::status_t         status_next;
    logic [swq_pkg::ID_W-1:0] woken_reg;
    logic [swq_pkg::ID_W-1:0] woken_next;

    logic              exec;
    logic              in_xfer;
    swq_pkg::cell_op_t op;
    swq_pkg::entry_t   cell_entry [CELLS];
    logic [CELLS-1:0]  cell_le;
    swq_pkg::entry_t   empty_entry;
    swq_pkg::entry_t   head;

    assign in_stall   = stage_valid_reg;
    assign in_xfer    = in_valid && !in_stall;
    assign exec       = stage_valid_reg && (!out_valid_reg || !out_stall);
    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign woken_task = woken_reg;
    assign head       = cell_entry[0];

    assign empty_entry.valid = 1'b0;
    assign empty_entry.tick  = '0;
    assign empty_entry.id    = '0;

    // Checks and the resulting cell operation, count, marks and result.
    always_comb
    begin
        op.ins         = 1'b0;
        op.pop         = 1'b0;
        count_next     = count_reg;
        mark_next      = mark_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        woken_next     = woken_reg;
        if (exec)
        begin
            out_valid_next = 1'b1;
            woken_next     = '0;
            if (stage_cmd_reg == swq_pkg::CMD_ADD)
            begin
                if (stage_id_reg > LIMIT_ID)
                begin
                    status_next = swq_pkg::ST_BAD_ID;
                end
                else if (count_reg >= FULL_CNT)
                begin
                    status_next = swq_pkg::ST_FULL;
                end
                else if (mark_reg[stage_id_reg[MARK_W-1:0]])
                begin
                    status_next = swq_pkg::ST_DUPLICATE;
                end
                else
                begin
                    status_next                        = swq_pkg::ST_OK;
                    op.ins                             = 1'b1;
                    count_next                         = count_reg + 1'b1;
                    mark_next[stage_id_reg[MARK_W-1:0]] = 1'b1;
                end
            end
            else
            begin
                if (count_reg == '0)
                begin
                    status_next = swq_pkg::ST_EMPTY;
                end
                else if (stage_tick_reg < head.tick)
                begin
                    status_next = swq_pkg::ST_NOT_DUE;
                end
                else
                begin
                    status_next                   = swq_pkg::ST_OK;
                    op.pop                        = 1'b1;
                    woken_next                    = head.id;
                    count_next                    = count_reg - 1'b1;
                    mark_next[head.id[MARK_W-1:0]] = 1'b0;
                end
            end
        end
    end

    // The command register fills on an input transfer and empties on execution.
    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (exec)
        begin
            stage_valid_next = 1'b0;
        end
        if (in_xfer)
        begin
            stage_valid_next = 1'b1;
        end
    end

    // The cell chain; cell zero is the head and always sees an open slot to its left.
    for (genvar i = 0; i < CELLS; i++)
    begin : g_cell
        swq_pkg::entry_t prev_e;
        swq_pkg::entry_t next_e;
        logic            prev_l;

        if (i == 0)
        begin : g_first
            assign prev_e = empty_entry;
            assign prev_l = 1'b1;
        end
        else
        begin : g_mid
            assign prev_e = cell_entry[i-1];
            assign prev_l = cell_le[i-1];
        end

        if (i == CELLS - 1)
        begin : g_last
            assign next_e = empty_entry;
        end
        else
        begin : g_inner
            assign next_e = cell_entry[i+1];
        end

        swq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .op         (op),
            .new_tick   (stage_tick_reg),
            .new_id     (stage_id_reg),
            .prev_entry (prev_e),
            .prev_le    (prev_l),
            .next_entry (next_e),
            .entry      (cell_entry[i]),
            .le         (cell_le[i])
        );
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            count_reg       <= '0;
            mark_reg        <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            count_reg       <= count_next;
            mark_reg        <= mark_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stage_cmd_reg  <= cmd;
            stage_id_reg   <= task_id;
            stage_tick_reg <= tick_value;
        end
        status_reg <= status_next;
        woken_reg  <= woken_next;
    end

endmodule

`default_nettype wire

// ===== verif/sorted_wakeup_queue_unit_tb.sv =====
// Testbench for sorted_wakeup_queue_unit: sends add and pop commands and checks each result
// against a behavioral copy of the sorted wake-up queue. Depends on swq_pkg and the RTL.
`timescale 1ns / 100ps

module sorted_wakeup_queue_unit_tb;

    localparam int QUEUE_SLOTS = 64;
    localparam int TASK_LIMIT  = 63;
    localparam int RANDOM_ITEMS = 1300;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 16;

    // One command as sent to the block.
    typedef struct {
        logic                       op;
        logic [swq_pkg::ID_W-1:0]   id;
        logic [swq_pkg::TICK_W-1:0] tick;
    } wake_cmd_t;

    // One result as predicted.
    typedef struct {
        swq_pkg::status_t         code;
        logic [swq_pkg::ID_W-1:0] woken;
    } wake_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       cmd = swq_pkg::CMD_ADD;
    logic [swq_pkg::ID_W-1:0]   task_id = '0;
    logic [swq_pkg::TICK_W-1:0] tick_value = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [2:0]                 status;
    logic [swq_pkg::ID_W-1:0]   woken_task;

    // Commands waiting to be sent and results waiting to arrive.
    wake_cmd_t    pending_cmds[$];
    wake_result_t expected_results[$];
    wake_cmd_t    cmd_on_bus;
    wake_result_t oldest_result;

    // Predicted queue contents.
    logic [swq_pkg::TICK_W-1:0] sleeper_tick[QUEUE_SLOTS];
    logic [swq_pkg::ID_W-1:0]   sleeper_id[QUEUE_SLOTS];
    int                         sleeper_count = 0;
    bit                         id_asleep[256];

    int total_cmds = 0;
    int accepted_count = 0;
    int fail_count = 0;
    int idle_cycles = 0;
    int src_gap = 0;
    int src_calm = 0;
    int sink_hold = 0;
    int sink_calm = 0;

    sorted_wakeup_queue_unit #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .TASK_LIMIT  (TASK_LIMIT)
    ) u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .task_id    (task_id),
        .tick_value (tick_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .woken_task (woken_task)
    );

    // Clock generation.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Applies one command to the predicted queue and returns the result it yields.
    function automatic wake_result_t predict_wakeup(wake_cmd_t c);
        wake_result_t res;
        int pos;
        res.code  = swq_pkg::ST_OK;
        res.woken = '0;
        if (c.op == swq_pkg::CMD_ADD)
        begin
            if (c.id > TASK_LIMIT)
                res.code = swq_pkg::ST_BAD_ID;
            else if (sleeper_count >= QUEUE_SLOTS - 1)
                res.code = swq_pkg::ST_FULL;
            else if (id_asleep[c.id])
                res.code = swq_pkg::ST_DUPLICATE;
            else
            begin
                // Insert after every entry with an equal or earlier tick.
                pos = 0;
                while (pos < sleeper_count && sleeper_tick[pos] <= c.tick)
                    pos++;
                for (int k = sleeper_count; k > pos; k--)
                begin
                    sleeper_tick[k] = sleeper_tick[k-1];
                    sleeper_id[k]   = sleeper_id[k-1];
                end
                sleeper_tick[pos] = c.tick;
                sleeper_id[pos]   = c.id;
                sleeper_count++;
                id_asleep[c.id] = 1'b1;
            end
        end
        else
        begin
            if (sleeper_count == 0)
                res.code = swq_pkg::ST_EMPTY;
            else if (c.tick < sleeper_tick[0])
                res.code = swq_pkg::ST_NOT_DUE;
            else
            begin
                // The head is due: remove it and shift the rest forward.
                res.woken = sleeper_id[0];
                for (int k = 1; k < sleeper_count; k++)
                begin
                    sleeper_tick[k-1] = sleeper_tick[k];
                    sleeper_id[k-1]   = sleeper_id[k];
                end
                sleeper_count--;
                id_asleep[res.woken] = 1'b0;
            end
        end
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    task automatic queue_cmd(logic op, logic [swq_pkg::ID_W-1:0] id,
                             logic [swq_pkg::TICK_W-1:0] tick);
        wake_cmd_t c;
        c.op   = op;
        c.id   = id;
        c.tick = tick;
        pending_cmds.push_back(c);
    endtask

    // Driver: presents pending commands with random gaps and predicts each transfer.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(predict_wakeup(cmd_on_bus));
                accepted_count++;
            end
            if (!in_valid || !in_stall)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_cmds.size() != 0)
                begin
                    cmd_on_bus = pending_cmds.pop_front();
                    cmd        <= cmd_on_bus.op;
                    task_id    <= cmd_on_bus.id;
                    tick_value <= cmd_on_bus.tick;
                    in_valid   <= 1'b1;
                    if (src_calm > 0)
                    begin
                        src_calm--;
                        src_gap = 0;
                    end
                    else
                    begin
                        src_gap = draw_gap();
                        if ($urandom_range(0, 29) == 0)
                            src_calm = $urandom_range(20, 80);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer and applies random stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no command outstanding: status %0d woken_task %0d",
                           status, woken_task);
                    fail_count++;
                end
                else
                begin
                    oldest_result = expected_results.pop_front();
                    if (status !== oldest_result.code)
                    begin
                        $error("status: expected %0d, actual %0d", oldest_result.code, status);
                        fail_count++;
                    end
                    if (woken_task !== oldest_result.woken)
                    begin
                        $error("woken_task: expected %0d, actual %0d",
                               oldest_result.woken, woken_task);
                        fail_count++;
                    end
                end
            end
            if (sink_hold > 0)
            begin
                sink_hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (sink_calm > 0)
                    sink_calm--;
                else
                begin
                    sink_hold = draw_gap();
                    if ($urandom_range(0, 29) == 0)
                        sink_calm = $urandom_range(20, 80);
                end
            end
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus and end of run.
    initial
    begin
        int ids[TASK_LIMIT+1];
        int mode;
        int n;
        int j;
        int tmp;
        logic [swq_pkg::TICK_W-1:0] base;
        logic [swq_pkg::TICK_W-1:0] now_tick;
        bit narrow;

        // Directed: empty pop, tick extremes, bad ids, duplicate, ties and not-due heads.
        queue_cmd(swq_pkg::CMD_POP, 8'h00, 32'h0000_0000);
        queue_cmd(swq_pkg::CMD_ADD, 8'd0, 32'h0000_0000);
        queue_cmd(swq_pkg::CMD_ADD, swq_pkg::ID_W'(TASK_LIMIT), 32'hFFFF_FFFF);
        queue_cmd(swq_pkg::CMD_ADD, swq_pkg::ID_W'(TASK_LIMIT + 1), 32'h0000_0010);
        queue_cmd(swq_pkg::CMD_ADD, 8'hFF, 32'hAAAA_5555);
        queue_cmd(swq_pkg::CMD_ADD, 8'd0, 32'h0000_0005);
        queue_cmd(swq_pkg::CMD_ADD, 8'd5, 32'd100);
        queue_cmd(swq_pkg::CMD_ADD, 8'd6, 32'd100);
        queue_cmd(swq_pkg::CMD_ADD, 8'd7, 32'd50);
        queue_cmd(swq_pkg::CMD_POP, 8'hAA, 32'd0);
        queue_cmd(swq_pkg::CMD_POP, 8'h55, 32'd49);
        queue_cmd(swq_pkg::CMD_POP, 8'hFF, 32'd50);
        queue_cmd(swq_pkg::CMD_POP, 8'h00, 32'd100);
        queue_cmd(swq_pkg::CMD_POP, 8'h00, 32'd100);
        queue_cmd(swq_pkg::CMD_POP, 8'h00, 32'hFFFF_FFFE);
        queue_cmd(swq_pkg::CMD_POP, 8'h00, 32'hFFFF_FFFF);
        queue_cmd(swq_pkg::CMD_POP, 8'h00, 32'hFFFF_FFFF);
        queue_cmd(swq_pkg::CMD_ADD, 8'd0, 32'h8000_0000);
        queue_cmd(swq_pkg::CMD_POP, 8'h00, 32'h7FFF_FFFF);
        queue_cmd(swq_pkg::CMD_POP, 8'h00, 32'h8000_0000);

        // Random: fill bursts up to full, mixed traffic on a moving tick, and drains.
        n = pending_cmds.size() + RANDOM_ITEMS;
        now_tick = $urandom;
        while (pending_cmds.size() < n)
        begin
            mode = $urandom_range(0, 9);
            if (mode < 2)
            begin
                // Every legal id once in random order, so the queue reaches full.
                for (int i = 0; i <= TASK_LIMIT; i++)
                    ids[i] = i;
                for (int i = TASK_LIMIT; i > 0; i--)
                begin
                    j = $urandom_range(0, i);
                    tmp = ids[i];
                    ids[i] = ids[j];
                    ids[j] = tmp;
                end
                base = $urandom;
                narrow = $urandom_range(0, 2) != 0;
                for (int i = 0; i <= TASK_LIMIT; i++)
                    queue_cmd(swq_pkg::CMD_ADD, swq_pkg::ID_W'(ids[i]),
                              narrow ? base + $urandom_range(0, 15) : $urandom);
                queue_cmd(swq_pkg::CMD_ADD, swq_pkg::ID_W'($urandom_range(0, TASK_LIMIT)),
                          $urandom);
                queue_cmd(swq_pkg::CMD_ADD,
                          swq_pkg::ID_W'($urandom_range(TASK_LIMIT + 1, 255)), $urandom);
            end
            else if (mode < 3)
            begin
                // Drain, mostly with the latest possible tick.
                for (int i = $urandom_range(20, 70); i > 0; i--)
                    queue_cmd(swq_pkg::CMD_POP, swq_pkg::ID_W'($urandom),
                              ($urandom_range(0, 3) != 0) ? 32'hFFFF_FFFF : $urandom);
            end
            else
            begin
                // Kernel-like traffic: sleeps a little ahead, ticks that advance slowly.
                for (int i = 0; i < 30; i++)
                begin
                    tmp = $urandom_range(0, 99);
                    if (tmp < 5)
                        queue_cmd(swq_pkg::CMD_ADD,
                                  swq_pkg::ID_W'($urandom_range(TASK_LIMIT + 1, 255)),
                                  $urandom);
                    else if (tmp < 50)
                        queue_cmd(swq_pkg::CMD_ADD,
                                  swq_pkg::ID_W'($urandom_range(0, TASK_LIMIT)),
                                  now_tick + $urandom_range(0, 40));
                    else
                    begin
                        queue_cmd(swq_pkg::CMD_POP, swq_pkg::ID_W'($urandom), now_tick);
                        now_tick = now_tick + $urandom_range(0, 6);
                    end
                end
            end
        end
        total_cmds = pending_cmds.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every command to be taken and every result to arrive.
        while (accepted_count < total_cmds || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
